### rtl/core/dcache_fifo_writeback_tag_lookup_assert.svh
// Assertion macros for the write-back tag directory.
`ifndef DCACHE_FIFO_WRITEBACK_TAG_LOOKUP_ASSERT_SVH
`define DCACHE_FIFO_WRITEBACK_TAG_LOOKUP_ASSERT_SVH

// Same-cycle implication, masked while reset is high
`define DFWTL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfwtl: same-cycle check failed");

// Next-cycle implication, also checked across reset
`define DFWTL_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("dfwtl: next-cycle check failed");

`endif

### rtl/core/dfwtl_pkg.sv
package dfwtl_pkg;

   // Geometry
   localparam int WAYS      = 4;
   localparam int SETS      = 128;
   localparam int TAG_WIDTH = 19;

   localparam int SET_WIDTH = $clog2(SETS);
   localparam int WAY_WIDTH = $clog2(WAYS);
   localparam int AGE_WIDTH = $clog2(WAYS);

   // Line status codes
   localparam logic [1:0] ST_INVALID   = 2'd0;
   localparam logic [1:0] ST_EXCLUSIVE = 2'd1;
   localparam logic [1:0] ST_MODIFIED  = 2'd2;

   localparam logic [AGE_WIDTH-1:0] AGE_NEWEST = AGE_WIDTH'(WAYS - 1);

   typedef struct packed {
      logic [1:0]           status;
      logic [TAG_WIDTH-1:0] tag;
      logic [AGE_WIDTH-1:0] age;
   } way_type;

   // One directory row holds every way of a set
   typedef way_type [WAYS-1:0] row_type;

endpackage

### rtl/core/dcache_fifo_writeback_tag_lookup.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    set_index, line_tag, is_write
// rsp       out        rsp_valid/rsp_ready    hit, replaced, writeback_valid, writeback_tag
//
// One transaction per cycle sustained while rsp_ready stays high; an accepted req is
// registered in the lookup stage, then in the output register, which raises rsp_valid.
// The directory row of a set is read into a register on req acceptance and written back
// when the lookup stage advances; a write to the set read in the same cycle is forwarded.
// Reset clears the per-set row valid bits at once, no sweep. A stalled rsp holds its
// register; the lookup stage waits behind it.
module dcache_fifo_writeback_tag_lookup (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dfwtl_pkg::SET_WIDTH-1:0] req_set_index,
   input  logic [dfwtl_pkg::TAG_WIDTH-1:0] req_line_tag,
   input  logic                          req_is_write,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic                          rsp_replaced,
   output logic                          rsp_writeback_valid,
   output logic [dfwtl_pkg::TAG_WIDTH-1:0] rsp_writeback_tag
);
   import dfwtl_pkg::*;

   // Directory memory and per-row valid bits
   row_type              dir_mem_ff [SETS];
   logic [SETS-1:0]      row_vld_ff;

   // Lookup stage
   logic                 s1_valid_ff;
   logic [SET_WIDTH-1:0] s1_set_ff;
   logic [TAG_WIDTH-1:0] s1_tag_ff;
   logic                 s1_wr_ff;
   row_type              rd_row_ff;
   logic                 rd_vld_ff;
   logic                 bypass_ff;
   row_type              wr_row_ff;

   // Output register
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_repl_ff;
   logic                 rsp_wb_ff;
   logic [TAG_WIDTH-1:0] rsp_wb_tag_ff;

   logic                 req_fire;
   logic                 s1_adv;
   logic                 bypass_in;
   row_type              cur_row;
   row_type              new_row;
   logic [WAYS-1:0]      way_vld;
   logic [WAYS-1:0]      hit_vec;
   logic                 hit;
   logic                 have_inv;
   logic [WAY_WIDTH-1:0] inv_way;
   logic [WAY_WIDTH-1:0] age_way;
   logic [WAY_WIDTH-1:0] target;
   logic                 repl;
   logic                 wb;
   logic [TAG_WIDTH-1:0] wb_tag;

   // Handshake
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign bypass_in = s1_adv && (s1_set_ff == req_set_index);

   // Row seen by the lookup: forwarded write, stored row, or reset value
   always_comb begin
      if (bypass_ff) begin
         cur_row = wr_row_ff;
      end else if (rd_vld_ff) begin
         cur_row = rd_row_ff;
      end else begin
         cur_row = '0;
      end
   end

   // Tag compare, victim choice and row update
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         way_vld[w] = cur_row[w].status != ST_INVALID;
         hit_vec[w] = way_vld[w] && (cur_row[w].tag == s1_tag_ff);
      end
      hit      = |hit_vec;
      have_inv = ~&way_vld;

      // highest-numbered invalid way
      inv_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!way_vld[w]) begin
            inv_way = WAY_WIDTH'(w);
         end
      end

      // lowest-numbered way of age zero, way 0 if none
      age_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (cur_row[w].age == '0) begin
            age_way = WAY_WIDTH'(w);
         end
      end

      target = have_inv ? inv_way : age_way;
      repl   = !hit && !have_inv;
      wb     = repl && (cur_row[target].status == ST_MODIFIED);
      wb_tag = wb ? cur_row[target].tag : '0;

      new_row = cur_row;
      for (int w = 0; w < WAYS; w++) begin
         if (hit) begin
            if (hit_vec[w] && s1_wr_ff) begin
               new_row[w].status = ST_MODIFIED;
            end
         end else if (WAY_WIDTH'(w) == target) begin
            new_row[w].status = s1_wr_ff ? ST_MODIFIED : ST_EXCLUSIVE;
            new_row[w].tag    = s1_tag_ff;
            new_row[w].age    = AGE_NEWEST;
         end else if (way_vld[w] && (cur_row[w].age != '0)) begin
            new_row[w].age = cur_row[w].age - 1'b1;
         end
      end
   end

   // Directory memory: read on acceptance, write back when the lookup retires
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_row_ff <= dir_mem_ff[req_set_index];
      end
      if (s1_adv) begin
         dir_mem_ff[s1_set_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (s1_adv) begin
         row_vld_ff[s1_set_ff] <= 1'b1;
      end
   end

   // Lookup stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_set_ff <= req_set_index;
         s1_tag_ff <= req_line_tag;
         s1_wr_ff  <= req_is_write;
         rd_vld_ff <= row_vld_ff[req_set_index];
         bypass_ff <= bypass_in;
      end
      if (s1_adv) begin
         wr_row_ff <= new_row;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_hit_ff    <= hit;
         rsp_repl_ff   <= repl;
         rsp_wb_ff     <= wb;
         rsp_wb_tag_ff <= wb_tag;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_replaced        = rsp_repl_ff;
   assign rsp_writeback_valid = rsp_wb_ff;
   assign rsp_writeback_tag   = rsp_wb_tag_ff;

endmodule

### rtl/core/dfwtl_checker.sv
`include "dcache_fifo_writeback_tag_lookup_assert.svh"

module dfwtl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_hit,
   input logic                          rsp_replaced,
   input logic                          rsp_writeback_valid,
   input logic [dfwtl_pkg::TAG_WIDTH-1:0] rsp_writeback_tag
);
   import dfwtl_pkg::*;

   // a hit never evicts
   `DFWTL_ASSERT_NOW(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_replaced)
   // write-back only comes with an eviction
   `DFWTL_ASSERT_NOW(a_wb_needs_evict, clock, reset, rsp_valid && rsp_writeback_valid, rsp_replaced)
   // victim tag is zero when nothing is written back
   `DFWTL_ASSERT_NOW(a_wb_tag_zero, clock, reset, rsp_valid && !rsp_writeback_valid, rsp_writeback_tag == '0)
   // no transaction shown straight after reset
   `DFWTL_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind dcache_fifo_writeback_tag_lookup dfwtl_checker u_dfwtl_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_hit             (rsp_hit),
   .rsp_replaced        (rsp_replaced),
   .rsp_writeback_valid (rsp_writeback_valid),
   .rsp_writeback_tag   (rsp_writeback_tag)
);
